### rtl/sleb_pkg.sv
// package for the single-line edit buffer: field widths, opcodes, key codes
// and sequencer states; no dependencies
package sleb_pkg;

  localparam int STORE_DEPTH_DEF = 64;

  localparam int OP_W   = 2;
  localparam int KEY_W  = 9;
  localparam int BYTE_W = 8;
  localparam int IDX_W  = 6;
  localparam int POS_W  = 7;
  localparam int CFG_W  = 7;

  localparam logic [CFG_W-1:0] MAX_LEN_RST = 7'd64;

  typedef enum logic [OP_W-1:0] {
    OP_KEY    = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_APPEND = 2'd2,
    OP_READ   = 2'd3
  } sleb_op_t;

  localparam logic [KEY_W-1:0] K_CTRL_A    = 9'd1;
  localparam logic [KEY_W-1:0] K_CTRL_D    = 9'd4;
  localparam logic [KEY_W-1:0] K_CTRL_E    = 9'd5;
  localparam logic [KEY_W-1:0] K_CTRL_K    = 9'd11;
  localparam logic [KEY_W-1:0] K_BACKSPACE = 9'h07F;
  localparam logic [KEY_W-1:0] K_PRINT_LO  = 9'h020;
  localparam logic [KEY_W-1:0] K_PRINT_END = 9'h100;
  localparam logic [KEY_W-1:0] K_LEFT      = 9'd256;
  localparam logic [KEY_W-1:0] K_RIGHT     = 9'd257;
  localparam logic [KEY_W-1:0] K_HOME      = 9'd258;
  localparam logic [KEY_W-1:0] K_END       = 9'd259;
  localparam logic [KEY_W-1:0] K_DELETE    = 9'd260;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SHIFT,
    ST_DRAIN,
    ST_FIN,
    ST_RDATA,
    ST_DONE
  } sleb_state_t;

endpackage

### rtl/sleb_if.sv
// valid/ready channel interfaces for the edit buffer's request and result beats
// depends on sleb_pkg for the field widths
interface sleb_in_if import sleb_pkg::*;;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [KEY_W-1:0]  key;
  logic [BYTE_W-1:0] load_byte;
  logic [IDX_W-1:0]  read_index;

  modport source (output valid, opcode, key, load_byte, read_index, input ready);
  modport sink   (input valid, opcode, key, load_byte, read_index, output ready);
endinterface

interface sleb_out_if import sleb_pkg::*;;
  logic              valid;
  logic              ready;
  logic              handled;
  logic [POS_W-1:0]  cursor;
  logic [POS_W-1:0]  length;
  logic [BYTE_W-1:0] read_byte;

  modport source (output valid, handled, cursor, length, read_byte, input ready);
  modport sink   (input valid, handled, cursor, length, read_byte, output ready);
endinterface

### rtl/sleb_ram.sv
// generic single-write, single-read ram with registered read data
// depends on sleb_pkg for default sizes
module sleb_ram import sleb_pkg::*; #(
  parameter int WIDTH = BYTE_W,
  parameter int DEPTH = STORE_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/single_line_edit_buffer.sv
// single-line edit buffer: text ram, cursor, length and the shift sequencer
// depends on sleb_pkg, sleb_if (sleb_in_if, sleb_out_if) and sleb_ram
//
// usage: one request beat on in_if (opcode, key, load_byte, read_index) gives
// one result beat on out_if (handled, cursor, length, read_byte). opcode 0
// applies a key, 1 clears the text, 2 appends load_byte, 3 reads a byte back.
// cfg_we/cfg_wdata write max_length; write it only while the block is idle.
// in_if.ready is high only in the idle state: one request is worked at a time.
// the sequencer goes from exec straight to done for cursor moves, clear,
// ctrl-k, append, rejected keys and short reads; a read inside the text
// passes through rdata, and an insert or delete through fin, after shift
// and drain when it moves entries (the tail behind the cursor). the single
// write port of the text ram moves one entry a cycle, reads overlapping
// writes in a two-stage pipe.
// the result sits in an output register; a new request is accepted while it
// waits, and the next result waits in the sequencer until out_if.ready frees
// the register. reset (rst_n low at a clock edge) empties the text, puts the
// cursor at 0 and max_length at 64; the ram itself is not cleared.
module single_line_edit_buffer import sleb_pkg::*; #(
  parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  sleb_in_if.sink          in_if,
  sleb_out_if.source       out_if
);

  localparam int CAP = (STORE_DEPTH < 127) ? STORE_DEPTH : 127;
  localparam int LW  = $clog2(CAP + 1);
  localparam int AW  = $clog2(STORE_DEPTH);
  localparam logic [CFG_W-1:0] CAP_C = CFG_W'(CAP);

  function automatic logic [AW-1:0] pos_addr(input logic [LW-1:0] p);
    logic [AW+LW-1:0] w;
    w = {{AW{1'b0}}, p};
    return w[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] idx_addr(input logic [IDX_W-1:0] p);
    logic [AW+IDX_W-1:0] w;
    w = {{AW{1'b0}}, p};
    return w[AW-1:0];
  endfunction

  function automatic logic [POS_W-1:0] pos_port(input logic [LW-1:0] p);
    logic [POS_W+LW-1:0] w;
    w = {{POS_W{1'b0}}, p};
    return w[POS_W-1:0];
  endfunction

  sleb_state_t       state_r, state_nxt;
  logic [CFG_W-1:0]  max_len_r, max_len_nxt;
  logic [LW-1:0]     cursor_r, cursor_nxt;
  logic [LW-1:0]     len_r, len_nxt;
  logic [LW-1:0]     ptr_r, ptr_nxt;
  logic [LW-1:0]     wptr_r, wptr_nxt;
  logic              pend_r, pend_nxt;
  logic              ins_r, ins_nxt;
  logic              handled_r, handled_nxt;
  logic [BYTE_W-1:0] rd_r, rd_nxt;
  sleb_op_t          op_r, op_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [BYTE_W-1:0] lb_r, lb_nxt;
  logic [IDX_W-1:0]  ri_r, ri_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              out_handled_r, out_handled_nxt;
  logic [POS_W-1:0]  out_cursor_r, out_cursor_nxt;
  logic [POS_W-1:0]  out_length_r, out_length_nxt;
  logic [BYTE_W-1:0] out_rd_r, out_rd_nxt;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [BYTE_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;

  logic [CFG_W-1:0]  eff_max;
  logic              room;
  logic [LW-1:0]     cur_inc, cur_dec, len_inc, len_dec;
  logic              in_beat;

  sleb_ram #(.WIDTH(BYTE_W), .DEPTH(STORE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign eff_max = (max_len_r > CAP_C) ? CAP_C : max_len_r;
  assign room    = pos_port(len_r) < eff_max;
  assign cur_inc = LW'(cursor_r + 1'b1);
  assign cur_dec = LW'(cursor_r - 1'b1);
  assign len_inc = LW'(len_r + 1'b1);
  assign len_dec = LW'(len_r - 1'b1);

  assign in_if.ready = (state_r == ST_IDLE);
  assign in_beat     = in_if.valid && in_if.ready;

  assign out_if.valid     = out_valid_r;
  assign out_if.handled   = out_handled_r;
  assign out_if.cursor    = out_cursor_r;
  assign out_if.length    = out_length_r;
  assign out_if.read_byte = out_rd_r;

  // read port: request address in exec, shift pointer otherwise
  assign ram_raddr = (state_r == ST_EXEC) ? idx_addr(ri_r) : pos_addr(ptr_r);

  always_comb begin
    state_nxt       = state_r;
    max_len_nxt     = cfg_we ? cfg_wdata : max_len_r;
    cursor_nxt      = cursor_r;
    len_nxt         = len_r;
    ptr_nxt         = ptr_r;
    wptr_nxt        = wptr_r;
    pend_nxt        = 1'b0;
    ins_nxt         = ins_r;
    handled_nxt     = handled_r;
    rd_nxt          = rd_r;
    op_nxt          = op_r;
    key_nxt         = key_r;
    lb_nxt          = lb_r;
    ri_nxt          = ri_r;
    out_valid_nxt   = out_valid_r && !out_if.ready;
    out_handled_nxt = out_handled_r;
    out_cursor_nxt  = out_cursor_r;
    out_length_nxt  = out_length_r;
    out_rd_nxt      = out_rd_r;
    ram_we          = 1'b0;
    ram_waddr       = pos_addr(wptr_r);
    ram_wdata       = ram_rdata;

    // pending shift beat from the previous read lands here
    if (pend_r) begin
      ram_we = 1'b1;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_beat) begin
          op_nxt    = sleb_op_t'(in_if.opcode);
          key_nxt   = in_if.key;
          lb_nxt    = in_if.load_byte;
          ri_nxt    = in_if.read_index;
          state_nxt = ST_EXEC;
        end
      end

      ST_EXEC: begin
        handled_nxt = 1'b1;
        rd_nxt      = '0;
        state_nxt   = ST_DONE;
        unique case (op_r)
          OP_KEY: begin
            case (key_r) inside
              K_LEFT: begin
                if (cursor_r != '0) cursor_nxt = cur_dec;
              end
              K_RIGHT: begin
                if (cursor_r < len_r) cursor_nxt = cur_inc;
              end
              K_HOME, K_CTRL_A: begin
                cursor_nxt = '0;
              end
              K_END, K_CTRL_E: begin
                cursor_nxt = len_r;
              end
              K_CTRL_K: begin
                len_nxt = cursor_r;
              end
              K_BACKSPACE: begin
                if (cursor_r != '0) begin
                  cursor_nxt = cur_dec;
                  ins_nxt    = 1'b0;
                  ptr_nxt    = cursor_r;
                  state_nxt  = (cursor_r < len_r) ? ST_SHIFT : ST_FIN;
                end
              end
              K_DELETE, K_CTRL_D: begin
                if (cursor_r < len_r) begin
                  ins_nxt   = 1'b0;
                  ptr_nxt   = cur_inc;
                  state_nxt = (cur_inc < len_r) ? ST_SHIFT : ST_FIN;
                end
              end
              default: begin
                if (key_r >= K_PRINT_LO && key_r < K_PRINT_END && room) begin
                  ins_nxt   = 1'b1;
                  ptr_nxt   = len_dec;
                  state_nxt = (len_r > cursor_r) ? ST_SHIFT : ST_FIN;
                end else begin
                  handled_nxt = 1'b0;
                end
              end
            endcase
          end
          OP_CLEAR: begin
            len_nxt    = '0;
            cursor_nxt = '0;
          end
          OP_APPEND: begin
            if (lb_r != '0 && room) begin
              ram_we     = 1'b1;
              ram_waddr  = pos_addr(len_r);
              ram_wdata  = lb_r;
              len_nxt    = len_inc;
              cursor_nxt = len_inc;
            end else begin
              handled_nxt = 1'b0;
            end
          end
          OP_READ: begin
            handled_nxt = 1'b0;
            if ({{LW{1'b0}}, ri_r} < {{IDX_W{1'b0}}, len_r}) begin
              state_nxt = ST_RDATA;
            end
          end
          default: ;
        endcase
      end

      // one entry read per cycle, written back one place over in the next cycle
      ST_SHIFT: begin
        pend_nxt = 1'b1;
        if (ins_r) begin
          wptr_nxt = LW'(ptr_r + 1'b1);
          ptr_nxt  = LW'(ptr_r - 1'b1);
          if (ptr_r == cursor_r) state_nxt = ST_DRAIN;
        end else begin
          wptr_nxt = LW'(ptr_r - 1'b1);
          ptr_nxt  = LW'(ptr_r + 1'b1);
          if (ptr_r == len_dec) state_nxt = ST_DRAIN;
        end
      end

      ST_DRAIN: begin
        state_nxt = ST_FIN;
      end

      ST_FIN: begin
        if (ins_r) begin
          ram_we     = 1'b1;
          ram_waddr  = pos_addr(cursor_r);
          ram_wdata  = key_r[BYTE_W-1:0];
          cursor_nxt = cur_inc;
          len_nxt    = len_inc;
        end else begin
          len_nxt = len_dec;
        end
        state_nxt = ST_DONE;
      end

      ST_RDATA: begin
        rd_nxt    = ram_rdata;
        state_nxt = ST_DONE;
      end

      ST_DONE: begin
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt   = 1'b1;
          out_handled_nxt = handled_r;
          out_cursor_nxt  = pos_port(cursor_r);
          out_length_nxt  = pos_port(len_r);
          out_rd_nxt      = rd_r;
          state_nxt       = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      max_len_r   <= MAX_LEN_RST;
      cursor_r    <= '0;
      len_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      max_len_r   <= max_len_nxt;
      cursor_r    <= cursor_nxt;
      len_r       <= len_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r         <= ptr_nxt;
    wptr_r        <= wptr_nxt;
    ins_r         <= ins_nxt;
    handled_r     <= handled_nxt;
    rd_r          <= rd_nxt;
    op_r          <= op_nxt;
    key_r         <= key_nxt;
    lb_r          <= lb_nxt;
    ri_r          <= ri_nxt;
    out_handled_r <= out_handled_nxt;
    out_cursor_r  <= out_cursor_nxt;
    out_length_r  <= out_length_nxt;
    out_rd_r      <= out_rd_nxt;
  end

  // cursor stays inside the text between requests
  a_cursor_in_text: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (cursor_r <= len_r))
    else $error("cursor past end of text");

  // shift writes only happen while the shift pipe runs
  a_pend_in_shift: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (state_r == ST_SHIFT || state_r == ST_DRAIN))
    else $error("shift write outside shift sequence");

  // no write lands outside the usable store
  a_waddr_range: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (ram_waddr < CAP))
    else $error("text write beyond capacity");

  // a result beat is only raised from the done state
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result raised outside done state");

endmodule
